### src/sjfq_pkg.sv
package sjfq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_BITS_DEF  = 8;
	localparam int KEY_BITS_DEF = 16;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_PUT,
		S_RM_SCAN,
		S_DONE
	} state_t;

endpackage

### src/sjfq_in_if.sv
interface sjfq_in_if #(
	parameter int ID_BITS  = sjfq_pkg::ID_BITS_DEF,
	parameter int KEY_BITS = sjfq_pkg::KEY_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	sjfq_pkg::op_t        operation;
	logic [ID_BITS-1:0]   job_id;
	logic [KEY_BITS-1:0]  burst_time;

	modport source (output valid, output operation, output job_id, output burst_time,
		input ready);
	modport sink (input valid, input operation, input job_id, input burst_time,
		output ready);
endinterface

### src/sjfq_out_if.sv
interface sjfq_out_if #(
	parameter int ID_BITS  = sjfq_pkg::ID_BITS_DEF,
	parameter int KEY_BITS = sjfq_pkg::KEY_BITS_DEF,
	parameter int CNT_W    = $clog2(sjfq_pkg::DEPTH_DEF + 1)
);
	logic                 valid;
	logic                 ready;
	sjfq_pkg::status_t    status;
	logic [ID_BITS-1:0]   out_job_id;
	logic [KEY_BITS-1:0]  out_burst_time;
	logic [CNT_W-1:0]     occupancy;

	modport source (output valid, output status, output out_job_id, output out_burst_time,
		output occupancy, input ready);
	modport sink (input valid, input status, input out_job_id, input out_burst_time,
		input occupancy, output ready);
endinterface

### src/shortest_job_first_ready_queue.sv
// Sorted ready queue, one word at a time through a one-read, one-write entry memory.
// Insert: scan from the tail, one entry per cycle, shifting larger bursts up by one slot
// through the memory's one read and one write port, then write the new job into its slot.
// Remove: take the head and copy every other entry down one slot. Errors skip the scan.
// in_ch.ready is high only while idle; a finished result waits in the output register.
// Reset (arst_n low) empties the queue and drops any pending result; memory is not cleared.
module shortest_job_first_ready_queue #(
	parameter int DEPTH    = sjfq_pkg::DEPTH_DEF,
	parameter int ID_BITS  = sjfq_pkg::ID_BITS_DEF,
	parameter int KEY_BITS = sjfq_pkg::KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sjfq_in_if.sink     in_ch,
	sjfq_out_if.source  out_ch
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// entry memory and registered read port
	logic [ID_BITS-1:0]  mem_id_q  [DEPTH];
	logic [KEY_BITS-1:0] mem_key_q [DEPTH];
	logic [ID_BITS-1:0]  rd_id_q;
	logic [KEY_BITS-1:0] rd_key_q;

	// control state
	sjfq_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              out_valid_q, out_valid_d;

	// working registers
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [IDX_W-1:0]    pos_q, pos_d;
	logic [ID_BITS-1:0]  id_q, id_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	sjfq_pkg::status_t   res_status_q, res_status_d;
	logic [ID_BITS-1:0]  res_id_q, res_id_d;
	logic [KEY_BITS-1:0] res_key_q, res_key_d;

	// output register
	sjfq_pkg::status_t   out_status_q;
	logic [ID_BITS-1:0]  out_id_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [CNT_W-1:0]    out_occ_q;
	logic                out_load;

	// memory port controls
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [ID_BITS-1:0]  wid;
	logic [KEY_BITS-1:0] wkey;
	logic [IDX_W-1:0]    raddr;

	logic                in_fire;
	logic [CNT_W-1:0]    count_m1;
	logic [CNT_W-1:0]    idx_p1;

	assign in_ch.ready = (state_q == sjfq_pkg::S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign count_m1    = count_q - CNT_W'(1);
	assign idx_p1      = CNT_W'(idx_q) + CNT_W'(1);

	// sequence the scan and drive the memory port
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		out_valid_d  = out_valid_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		id_d         = id_q;
		key_d        = key_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		res_key_d    = res_key_q;
		out_load     = 1'b0;
		we           = 1'b0;
		waddr        = idx_q;
		wid          = rd_id_q;
		wkey         = rd_key_q;
		raddr        = idx_q;

		if (out_valid_q && out_ch.ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			sjfq_pkg::S_IDLE: begin
				if (in_fire) begin
					id_d         = in_ch.job_id;
					key_d        = in_ch.burst_time;
					res_status_d = sjfq_pkg::ST_OK;
					res_id_d     = '0;
					res_key_d    = '0;
					if (in_ch.operation == sjfq_pkg::OP_REMOVE) begin
						if (count_q == '0) begin
							res_status_d = sjfq_pkg::ST_UNDER;
							state_d      = sjfq_pkg::S_DONE;
						end else begin
							raddr   = '0;
							idx_d   = '0;
							state_d = sjfq_pkg::S_RM_SCAN;
						end
					end else begin
						if (count_q >= CNT_W'(DEPTH)) begin
							res_status_d = sjfq_pkg::ST_OVER;
							state_d      = sjfq_pkg::S_DONE;
						end else if (count_q == '0) begin
							pos_d   = '0;
							state_d = sjfq_pkg::S_INS_PUT;
						end else begin
							raddr   = count_m1[IDX_W-1:0];
							idx_d   = count_m1[IDX_W-1:0];
							state_d = sjfq_pkg::S_INS_SCAN;
						end
					end
				end
			end

			// read data holds entry idx_q; move it up while its burst is larger
			sjfq_pkg::S_INS_SCAN: begin
				if (rd_key_q > key_q) begin
					we    = 1'b1;
					waddr = idx_p1[IDX_W-1:0];
					if (idx_q == '0) begin
						pos_d   = '0;
						state_d = sjfq_pkg::S_INS_PUT;
					end else begin
						raddr = idx_q - IDX_W'(1);
						idx_d = idx_q - IDX_W'(1);
					end
				end else begin
					pos_d   = idx_p1[IDX_W-1:0];
					state_d = sjfq_pkg::S_INS_PUT;
				end
			end

			sjfq_pkg::S_INS_PUT: begin
				we      = 1'b1;
				waddr   = pos_q;
				wid     = id_q;
				wkey    = key_q;
				count_d = count_q + CNT_W'(1);
				state_d = sjfq_pkg::S_DONE;
			end

			// read data holds entry idx_q; take the head, copy the rest down
			sjfq_pkg::S_RM_SCAN: begin
				if (idx_q == '0) begin
					res_id_d  = rd_id_q;
					res_key_d = rd_key_q;
				end else begin
					we    = 1'b1;
					waddr = idx_q - IDX_W'(1);
				end
				if (idx_p1 < count_q) begin
					raddr = idx_p1[IDX_W-1:0];
					idx_d = idx_p1[IDX_W-1:0];
				end else begin
					count_d = count_m1;
					state_d = sjfq_pkg::S_DONE;
				end
			end

			sjfq_pkg::S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = sjfq_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = sjfq_pkg::S_IDLE;
			end
		endcase
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sjfq_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// hold working and result words
	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		id_q         <= id_d;
		key_q        <= key_d;
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		res_key_q    <= res_key_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_key_q    <= res_key_q;
			out_occ_q    <= count_q;
		end
	end

	// write and read the entry memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem_id_q[waddr]  <= wid;
			mem_key_q[waddr] <= wkey;
		end
		rd_id_q  <= mem_id_q[raddr];
		rd_key_q <= mem_key_q[raddr];
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.out_job_id     = out_id_q;
	assign out_ch.out_burst_time = out_key_q;
	assign out_ch.occupancy      = out_occ_q;

endmodule

### tb/tb_shortest_job_first_ready_queue.sv
`timescale 1ns / 1ps

localparam int SJF_DEPTH = sjfq_pkg::DEPTH_DEF;
localparam int SJF_ID_W  = sjfq_pkg::ID_BITS_DEF;
localparam int SJF_KEY_W = sjfq_pkg::KEY_BITS_DEF;
localparam int SJF_CNT_W = $clog2(sjfq_pkg::DEPTH_DEF + 1);

typedef struct packed {
	sjfq_pkg::status_t      status;
	logic [SJF_ID_W-1:0]    job_id;
	logic [SJF_KEY_W-1:0]   burst;
	logic [SJF_CNT_W-1:0]   occupancy;
} sjf_result_t;

// Mirror of the sorted job queue plus the results still owed by the block
class sjf_queue_tracker;
	logic [SJF_ID_W-1:0]  job_ids[SJF_DEPTH];
	logic [SJF_KEY_W-1:0] job_bursts[SJF_DEPTH];
	int unsigned          job_count;
	sjf_result_t          pending_results[$];
	int                   errors;
	int                   n_words;
	int                   n_removed;
	int                   n_under;
	int                   n_over;
	int                   peak;

	function new();
		job_count = 0;
		errors    = 0;
		n_words   = 0;
		n_removed = 0;
		n_under   = 0;
		n_over    = 0;
		peak      = 0;
	endfunction

	task report(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function int pending();
		return pending_results.size();
	endfunction

	// Update the queue for one accepted word and queue the result it owes
	function void predict_word(sjfq_pkg::op_t op, logic [SJF_ID_W-1:0] id,
		logic [SJF_KEY_W-1:0] burst);
		sjf_result_t r;
		int unsigned pos;
		r = '0;
		r.status = sjfq_pkg::ST_OK;
		n_words++;
		if (op == sjfq_pkg::OP_REMOVE) begin
			if (job_count == 0) begin
				r.status = sjfq_pkg::ST_UNDER;
				n_under++;
			end else begin
				r.job_id = job_ids[0];
				r.burst  = job_bursts[0];
				for (int i = 1; i < job_count; i++) begin
					job_ids[i-1]    = job_ids[i];
					job_bursts[i-1] = job_bursts[i];
				end
				job_count--;
				n_removed++;
			end
		end else begin
			if (job_count >= SJF_DEPTH) begin
				r.status = sjfq_pkg::ST_OVER;
				n_over++;
			end else begin
				// stable: go behind every queued job with an equal or smaller burst
				pos = 0;
				while (pos < job_count && job_bursts[pos] <= burst)
					pos++;
				for (int i = int'(job_count); i > pos; i--) begin
					job_ids[i]    = job_ids[i-1];
					job_bursts[i] = job_bursts[i-1];
				end
				job_ids[pos]    = id;
				job_bursts[pos] = burst;
				job_count++;
			end
		end
		if (job_count > peak)
			peak = int'(job_count);
		r.occupancy = SJF_CNT_W'(job_count);
		pending_results.push_back(r);
	endfunction

	// Compare one accepted result against the oldest one owed
	task check_result(sjfq_pkg::status_t st, logic [SJF_ID_W-1:0] id,
		logic [SJF_KEY_W-1:0] burst, logic [SJF_CNT_W-1:0] occ);
		sjf_result_t e;
		if (pending_results.size() == 0) begin
			report($sformatf("result with nothing owed: status %0d id %0d burst %0d occ %0d",
				st, id, burst, occ));
		end else begin
			e = pending_results.pop_front();
			if (st !== e.status)
				report($sformatf("status %0d, want %0d", st, e.status));
			if (id !== e.job_id)
				report($sformatf("job id %0d, want %0d", id, e.job_id));
			if (burst !== e.burst)
				report($sformatf("burst %0d, want %0d", burst, e.burst));
			if (occ !== e.occupancy)
				report($sformatf("occupancy %0d, want %0d", occ, e.occupancy));
		end
	endtask
endclass

module tb_shortest_job_first_ready_queue;

	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = SJF_DEPTH + 8;
	localparam int SEGMENTS    = 8;
	localparam int SEG_WORDS   = 190;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   quiet_cycles;

	sjf_queue_tracker tracker = new();

	sjfq_in_if  in_ch ();
	sjfq_out_if out_ch ();

	shortest_job_first_ready_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Take results with random back-pressure and check them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				tracker.check_result(out_ch.status, out_ch.out_job_id, out_ch.out_burst_time,
					out_ch.occupancy);
			out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word after a random idle gap and hold it until accepted
	task automatic send_word(sjfq_pkg::op_t op, logic [SJF_ID_W-1:0] id,
		logic [SJF_KEY_W-1:0] burst);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < tx_idle_pct && gap < 200)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.job_id     <= id;
		in_ch.burst_time <= burst;
		do @(posedge clk); while (!in_ch.ready);
		tracker.predict_word(op, id, burst);
	endtask

	// Drop valid and hold off until every owed result has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic set_pacing(int mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
			default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
		endcase
	endtask

	// Random words: insert bias steers the queue toward full or empty
	task automatic random_words(int n, int ins_pct);
		sjfq_pkg::op_t        op;
		logic [SJF_ID_W-1:0]  id;
		logic [SJF_KEY_W-1:0] burst;
		int                   pick;
		for (int k = 0; k < n; k++) begin
			op   = ($urandom_range(0, 99) < ins_pct) ? sjfq_pkg::OP_INSERT
				: sjfq_pkg::OP_REMOVE;
			id   = SJF_ID_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 9);
			if (pick < 4)
				burst = SJF_KEY_W'($urandom_range(0, 7));
			else if (pick == 4)
				burst = $urandom_range(0, 1) ? {SJF_KEY_W{1'b1}} : '0;
			else
				burst = SJF_KEY_W'($urandom_range(0, 65535));
			send_word(op, id, burst);
		end
	endtask

	initial begin
		int bias[SEGMENTS];
		bias = '{75, 25, 60, 40, 90, 10, 55, 50};

		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.operation  = sjfq_pkg::OP_INSERT;
		in_ch.job_id     = '0;
		in_ch.burst_time = '0;
		tx_idle_pct      = 0;
		rx_stall_pct     = 0;
		quiet_cycles     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty remove, extremes, ties, a middle insert, full drain
		send_word(sjfq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
		send_word(sjfq_pkg::OP_INSERT, 8'h00, 16'h0000);
		send_word(sjfq_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
		send_word(sjfq_pkg::OP_INSERT, 8'h12, 16'h0000);
		send_word(sjfq_pkg::OP_INSERT, 8'h34, 16'h8000);
		send_word(sjfq_pkg::OP_INSERT, 8'h56, 16'h8000);
		send_word(sjfq_pkg::OP_INSERT, 8'hC3, 16'hFFFF);
		send_word(sjfq_pkg::OP_INSERT, 8'h81, 16'h00FF);
		repeat (7) send_word(sjfq_pkg::OP_REMOVE, 8'h00, 16'h0000);
		send_word(sjfq_pkg::OP_REMOVE, 8'hAA, 16'h5555);
		drain_results();

		// Random segments over every pacing mode, draining between them
		for (int s = 0; s < SEGMENTS; s++) begin
			set_pacing(s % 4);
			random_words(SEG_WORDS, bias[s]);
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.pending()));

		$display("Covered %0d words: %0d jobs removed, %0d underflows, %0d overflows",
			tracker.n_words, tracker.n_removed, tracker.n_under, tracker.n_over);
		$display("Peak occupancy %0d, four pacing modes, %0d mismatches",
			tracker.peak, tracker.errors);
		if (tracker.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
